>>> design/mtsu_pkg.sv
// ----------------------------------------------------------------------------
// mtsu_pkg
// Shared codes, register indexes, the config type and the beat type of the mosaic unpacker.
// ----------------------------------------------------------------------------
package mtsu_pkg;

    // operation codes carried with each input beat
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_ADD   = 2'd1;
    localparam logic [1:0] FUNC_READ  = 2'd2;

    // configuration register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_READ_RES  = 2'd0;
    localparam logic [1:0] REG_PHASE_RES = 2'd1;
    localparam logic [1:0] REG_SLICE_CNT = 2'd2;
    localparam logic [1:0] REG_TILES     = 2'd3;

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;
    localparam int IDX_W   = 18;
    localparam int PIX_W   = 16;
    localparam int COUNT_W = 20;
    localparam int SCNT_W  = 9;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    localparam logic [9:0] RST_READ_RES  = 10'd64;
    localparam logic [9:0] RST_PHASE_RES = 10'd64;
    localparam logic [8:0] RST_SLICE_CNT = 9'd1;
    localparam logic [4:0] RST_TILES     = 5'd1;

    typedef struct packed {
        logic [9:0] read_resolution;
        logic [9:0] phase_resolution;
        logic [8:0] slice_count;
        logic [4:0] tiles_per_side;
    } t_cfg;

    // one beat handed from the address pipeline to the store stage
    typedef struct packed {
        logic [1:0]              func;
        logic signed [PIX_W-1:0] pixel;
        logic                    ok;
        logic                    status;
        logic [IDX_W-1:0]        dest_index;
    } t_req;

endpackage

>>> design/mosaic_to_slice_unpacker_unit.sv
// ----------------------------------------------------------------------------
// mosaic_to_slice_unpacker_unit
// Unpacks a tiled mosaic image, one pixel per beat, into a stack of slices.
// The block takes one beat every clock cycle while the output is not stalled
// and returns one result beat for each: three pipeline stages compute the
// slice, the flipped row and the voxel address (one multiplier each), the
// slice store is read at the fourth, and the modified voxel is written back
// while the result enters the output register.
// The store is a single memory with one read and one write port; a write and
// a following read or add of the same voxel are bypassed, so any pattern of
// addresses runs at full rate. The store is not cleared after reset: read or
// add only voxels that were written. Geometry registers must be written
// while no beat is in flight; their products are registered after a write.
// ----------------------------------------------------------------------------
module mosaic_to_slice_unpacker_unit #(
    parameter int STORE_DEPTH        = 262144,
    parameter int MAX_RESOLUTION     = 512,
    parameter int MAX_TILES_PER_SIDE = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mtsu_pkg::PADDR_W-1:0]      paddr,
    input  logic [mtsu_pkg::PDATA_W-1:0]      pwdata,
    output logic [mtsu_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [mtsu_pkg::PIX_W-1:0] i_pixel,
    input  logic                              i_last_pixel,
    input  logic [mtsu_pkg::IDX_W-1:0]        i_voxel_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mtsu_pkg::IDX_W-1:0]        o_dest_index,
    output logic signed [mtsu_pkg::PIX_W-1:0] o_value,
    output logic                              o_in_slice,
    output logic                              o_status
);

    localparam int AW = $clog2(STORE_DEPTH);

    mtsu_pkg::t_cfg cfg;
    mtsu_pkg::t_req s3_req;
    logic [AW-1:0]  s3_addr;
    logic           s3_valid;
    logic           s3_ready;

    mtsu_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mtsu_addr #(
        .STORE_DEPTH        (STORE_DEPTH),
        .MAX_RESOLUTION     (MAX_RESOLUTION),
        .MAX_TILES_PER_SIDE (MAX_TILES_PER_SIDE)
    ) u_addr (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_pixel       (i_pixel),
        .i_last_pixel  (i_last_pixel),
        .i_voxel_index (i_voxel_index),
        .o_valid       (s3_valid),
        .i_ready       (s3_ready),
        .o_req         (s3_req),
        .o_addr        (s3_addr)
    );

    mtsu_store #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s3_valid),
        .o_ready      (s3_ready),
        .i_req        (s3_req),
        .i_addr       (s3_addr),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_dest_index (o_dest_index),
        .o_value      (o_value),
        .o_in_slice   (o_in_slice),
        .o_status     (o_status)
    );

    // input back-pressure only when every stage is full and the output stalls
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> (o_valid && !i_ready))
        else $error("input stalled while the pipeline has room");

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat valid right after reset");

    // a dropped pixel reports a zero address and value, also with bad status
    a_dropped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status && !o_in_slice) |-> (o_dest_index == '0 && o_value == '0))
        else $error("dropped pixel carries address or value");

    // bad-mosaic status rides only on write or add beats
    a_store_status_pix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s3_valid && s3_req.status) |->
        (s3_req.func == mtsu_pkg::FUNC_WRITE || s3_req.func == mtsu_pkg::FUNC_ADD))
        else $error("bad-mosaic status on a non-pixel beat");

endmodule

>>> design/mtsu_cfg.sv
// ----------------------------------------------------------------------------
// mtsu_cfg
// APB register file holding the four geometry registers.
// ----------------------------------------------------------------------------
module mtsu_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mtsu_pkg::PADDR_W-1:0]  paddr,
    input  logic [mtsu_pkg::PDATA_W-1:0]  pwdata,
    output logic [mtsu_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output mtsu_pkg::t_cfg                o_cfg
);

    mtsu_pkg::t_cfg r_cfg;
    mtsu_pkg::t_cfg n_cfg;
    logic           wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (paddr[3:2])
                mtsu_pkg::REG_READ_RES:  n_cfg.read_resolution  = pwdata[9:0];
                mtsu_pkg::REG_PHASE_RES: n_cfg.phase_resolution = pwdata[9:0];
                mtsu_pkg::REG_SLICE_CNT: n_cfg.slice_count      = pwdata[8:0];
                mtsu_pkg::REG_TILES:     n_cfg.tiles_per_side   = pwdata[4:0];
                default:                 n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.read_resolution  <= mtsu_pkg::RST_READ_RES;
            r_cfg.phase_resolution <= mtsu_pkg::RST_PHASE_RES;
            r_cfg.slice_count      <= mtsu_pkg::RST_SLICE_CNT;
            r_cfg.tiles_per_side   <= mtsu_pkg::RST_TILES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        case (paddr[3:2])
            mtsu_pkg::REG_READ_RES:  prdata = mtsu_pkg::PDATA_W'(r_cfg.read_resolution);
            mtsu_pkg::REG_PHASE_RES: prdata = mtsu_pkg::PDATA_W'(r_cfg.phase_resolution);
            mtsu_pkg::REG_SLICE_CNT: prdata = mtsu_pkg::PDATA_W'(r_cfg.slice_count);
            mtsu_pkg::REG_TILES:     prdata = mtsu_pkg::PDATA_W'(r_cfg.tiles_per_side);
            default:                 prdata = '0;
        endcase
    end

endmodule

>>> design/mtsu_addr.sv
// ----------------------------------------------------------------------------
// mtsu_addr
// Tile counters and a three-stage pipeline that turns a mosaic position into
// a voxel address, plus the mosaic size check at the last pixel.
// ----------------------------------------------------------------------------
module mtsu_addr #(
    parameter int STORE_DEPTH        = 262144,
    parameter int MAX_RESOLUTION     = 512,
    parameter int MAX_TILES_PER_SIDE = 16,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mtsu_pkg::t_cfg                    i_cfg,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_func,
    input  logic signed [mtsu_pkg::PIX_W-1:0] i_pixel,
    input  logic                              i_last_pixel,
    input  logic [mtsu_pkg::IDX_W-1:0]        i_voxel_index,
    output logic                              o_valid,
    input  logic                              i_ready,
    output mtsu_pkg::t_req                    o_req,
    output logic [AW-1:0]                     o_addr
);

    localparam int RW   = $clog2(MAX_RESOLUTION + 1);
    localparam int CW   = $clog2(MAX_RESOLUTION);
    localparam int TCW  = $clog2(MAX_TILES_PER_SIDE + 1);
    localparam int SW   = 2 * TCW;
    localparam int TW   = SW + RW;
    localparam int AFW  = TW + RW;
    localparam int WA   = (AFW > AW + 1) ? AFW : AW + 1;
    localparam int WW   = (WA > mtsu_pkg::IDX_W) ? WA : mtsu_pkg::IDX_W;
    localparam int CMPW = (AFW > mtsu_pkg::COUNT_W) ? AFW : mtsu_pkg::COUNT_W;
    localparam int SCW  = (SW > mtsu_pkg::SCNT_W) ? SW : mtsu_pkg::SCNT_W;
    localparam int PW   = mtsu_pkg::PIX_W;
    localparam int XW   = mtsu_pkg::IDX_W;
    localparam int NW   = mtsu_pkg::COUNT_W;

    // clamped geometry
    logic [RW-1:0]  rr;
    logic [RW-1:0]  pr;
    logic [TCW-1:0] tps;

    always_comb begin
        if (i_cfg.read_resolution == '0) begin
            rr = RW'(1);
        end else if (32'(i_cfg.read_resolution) > MAX_RESOLUTION) begin
            rr = RW'(MAX_RESOLUTION);
        end else begin
            rr = RW'(i_cfg.read_resolution);
        end
        if (i_cfg.phase_resolution == '0) begin
            pr = RW'(1);
        end else if (32'(i_cfg.phase_resolution) > MAX_RESOLUTION) begin
            pr = RW'(MAX_RESOLUTION);
        end else begin
            pr = RW'(i_cfg.phase_resolution);
        end
        if (i_cfg.tiles_per_side == '0) begin
            tps = TCW'(1);
        end else if (32'(i_cfg.tiles_per_side) > MAX_TILES_PER_SIDE) begin
            tps = TCW'(MAX_TILES_PER_SIDE);
        end else begin
            tps = TCW'(i_cfg.tiles_per_side);
        end
    end

    // registered products of the geometry, updated after a register write
    logic [SW-1:0]       r_tiles;
    logic [2*RW-1:0]     r_rp;
    logic [AFW-1:0]      r_expect;
    logic                r_sc_bad;

    always_ff @(posedge i_clk) begin
        r_tiles  <= SW'(SW'(tps) * SW'(tps));
        r_rp     <= (2*RW)'((2*RW)'(rr) * (2*RW)'(pr));
        r_expect <= AFW'(AFW'(r_rp) * AFW'(r_tiles));
        r_sc_bad <= SCW'(i_cfg.slice_count) > SCW'(r_tiles);
    end

    // pipeline handshake
    logic r_v1, r_v2, r_v3;
    logic en1, en2, en3;

    assign en3     = !r_v3 || i_ready;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
        end
    end

    // tile counters
    logic [CW-1:0]  r_col, r_row, n_col, n_row;
    logic [TCW-1:0] r_tcol, r_trow, n_tcol, n_trow;
    logic [NW-1:0]  r_cnt, n_cnt, cnt0;
    logic [RW:0]    col_inc, row_inc;
    logic [TCW:0]   tcol_inc;
    logic           col_wrap, row_wrap, tcol_wrap, trow_lt;
    logic           in_pix, acc_pix, in_rng0;
    logic [SW-1:0]  slice0;
    logic [RW-1:0]  flip0;

    assign in_pix    = (i_func == mtsu_pkg::FUNC_WRITE) || (i_func == mtsu_pkg::FUNC_ADD);
    assign acc_pix   = i_valid && en1 && in_pix;
    assign col_inc   = (RW+1)'(r_col) + (RW+1)'(1);
    assign row_inc   = (RW+1)'(r_row) + (RW+1)'(1);
    assign tcol_inc  = (TCW+1)'(r_tcol) + (TCW+1)'(1);
    assign col_wrap  = col_inc >= (RW+1)'(rr);
    assign row_wrap  = row_inc >= (RW+1)'(pr);
    assign tcol_wrap = tcol_inc >= (TCW+1)'(tps);
    assign trow_lt   = r_trow < tps;
    assign cnt0      = (r_cnt == mtsu_pkg::COUNT_MAX) ? r_cnt : r_cnt + NW'(1);
    assign in_rng0   = (RW'(r_col) < rr) && (RW'(r_row) < pr) && (r_tcol < tps) && trow_lt;
    assign slice0    = SW'(SW'(r_trow) * SW'(tps) + SW'(r_tcol));
    // rows inside a tile run bottom-up along the phase direction
    assign flip0     = pr - RW'(1) - RW'(r_row);

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_tcol = r_tcol;
        n_trow = r_trow;
        n_cnt  = r_cnt;
        if (acc_pix) begin
            n_cnt = cnt0;
            n_col = col_wrap ? '0 : CW'(col_inc);
            if (col_wrap) begin
                n_tcol = tcol_wrap ? '0 : TCW'(tcol_inc);
                if (tcol_wrap) begin
                    n_row = row_wrap ? '0 : CW'(row_inc);
                    if (row_wrap && trow_lt) n_trow = r_trow + TCW'(1);
                end
            end
            if (i_last_pixel) begin
                n_col  = '0;
                n_row  = '0;
                n_tcol = '0;
                n_trow = '0;
                n_cnt  = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_tcol <= '0;
            r_trow <= '0;
            r_cnt  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_tcol <= n_tcol;
            r_trow <= n_trow;
            r_cnt  <= n_cnt;
        end
    end

    // stage 1: slice and flipped row; stage 2: slice times rows plus flipped row
    logic [1:0]    r_func1, r_func2, r_func3;
    logic [PW-1:0] r_pix1, r_pix2, r_pix3;
    logic          r_last1, r_last2, r_last3;
    logic [XW-1:0] r_vidx1, r_vidx2, r_vidx3;
    logic [NW-1:0] r_cnt1, r_cnt2, r_cnt3;
    logic [SW-1:0] r_slice1;
    logic [RW-1:0] r_flip1;
    logic [CW-1:0] r_col1, r_col2;
    logic          r_inr1, r_sok2, r_sok3;
    logic [TW-1:0] r_t2;
    logic [AFW-1:0] r_addr3;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_func1  <= i_func;
            r_pix1   <= i_pixel;
            r_last1  <= i_last_pixel;
            r_vidx1  <= i_voxel_index;
            r_cnt1   <= cnt0;
            r_slice1 <= slice0;
            r_flip1  <= flip0;
            r_col1   <= r_col;
            r_inr1   <= in_rng0;
        end
        if (en2) begin
            r_func2 <= r_func1;
            r_pix2  <= r_pix1;
            r_last2 <= r_last1;
            r_vidx2 <= r_vidx1;
            r_cnt2  <= r_cnt1;
            r_col2  <= r_col1;
            r_t2    <= TW'(TW'(r_slice1) * TW'(pr) + TW'(r_flip1));
            r_sok2  <= r_inr1 && (SCW'(r_slice1) < SCW'(i_cfg.slice_count));
        end
        if (en3) begin
            r_func3 <= r_func2;
            r_pix3  <= r_pix2;
            r_last3 <= r_last2;
            r_vidx3 <= r_vidx2;
            r_cnt3  <= r_cnt2;
            r_sok3  <= r_sok2;
            r_addr3 <= AFW'(AFW'(r_t2) * AFW'(rr) + AFW'(r_col2));
        end
    end

    // stage 3: range checks and status
    logic [WW-1:0] addr_w, vidx_w, depth_w;
    logic          pix3, rd3, pix_ok, rd_ok;

    assign addr_w  = WW'(r_addr3);
    assign vidx_w  = WW'(r_vidx3);
    assign depth_w = WW'(STORE_DEPTH);
    assign pix3    = (r_func3 == mtsu_pkg::FUNC_WRITE) || (r_func3 == mtsu_pkg::FUNC_ADD);
    assign rd3     = r_func3 == mtsu_pkg::FUNC_READ;
    assign pix_ok  = r_sok3 && (addr_w < depth_w);
    assign rd_ok   = vidx_w < depth_w;

    always_comb begin
        o_req.func   = r_func3;
        o_req.pixel  = r_pix3;
        o_req.ok     = (pix3 && pix_ok) || (rd3 && rd_ok);
        o_req.status = pix3 && r_last3 &&
                       ((CMPW'(r_cnt3) != CMPW'(r_expect)) || r_sc_bad);
        if (pix3 && pix_ok) begin
            o_req.dest_index = addr_w[XW-1:0];
        end else if (rd3) begin
            o_req.dest_index = r_vidx3;
        end else begin
            o_req.dest_index = '0;
        end
        o_addr = rd3 ? vidx_w[AW-1:0] : addr_w[AW-1:0];
    end

endmodule

>>> design/mtsu_store.sv
// ----------------------------------------------------------------------------
// mtsu_store
// Slice store: synchronous read, modify, write back, with a bypass
// of the last write, and the output register of the result channel.
// ----------------------------------------------------------------------------
module mtsu_store #(
    parameter int STORE_DEPTH = 262144,
    localparam int AW = $clog2(STORE_DEPTH)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  mtsu_pkg::t_req                    i_req,
    input  logic [AW-1:0]                     i_addr,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [mtsu_pkg::IDX_W-1:0]        o_dest_index,
    output logic signed [mtsu_pkg::PIX_W-1:0] o_value,
    output logic                              o_in_slice,
    output logic                              o_status
);

    localparam int PW = mtsu_pkg::PIX_W;

    logic [PW-1:0] mem [STORE_DEPTH];

    logic           r_v4;
    mtsu_pkg::t_req r_req4;
    logic [AW-1:0]  r_addr4;
    logic [PW-1:0]  r_rdata;
    logic           r_fwd_v;
    logic [AW-1:0]  r_fwd_addr;
    logic [PW-1:0]  r_fwd_data;
    logic           r_ov;
    logic [mtsu_pkg::IDX_W-1:0] r_dest;
    logic [PW-1:0]  r_value;
    logic           r_in_slice;
    logic           r_status;

    logic          en4, en5, is_pix, wr_en;
    logic [PW-1:0] cur, nv;

    assign en5     = !r_ov || i_ready;
    assign en4     = !r_v4 || en5;
    assign o_ready = en4;

    assign is_pix = (r_req4.func == mtsu_pkg::FUNC_WRITE) ||
                    (r_req4.func == mtsu_pkg::FUNC_ADD);
    // the write leaving this stage lands on the same edge as the next read
    assign cur    = (r_fwd_v && (r_fwd_addr == r_addr4)) ? r_fwd_data : r_rdata;
    assign wr_en  = r_v4 && en5 && r_req4.ok && is_pix;

    always_comb begin
        case (r_req4.func)
            mtsu_pkg::FUNC_WRITE: nv = r_req4.pixel;
            mtsu_pkg::FUNC_ADD:   nv = cur + r_req4.pixel;
            mtsu_pkg::FUNC_READ:  nv = cur;
            default:              nv = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en4) r_rdata <= mem[i_addr];
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[r_addr4] <= nv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4    <= 1'b0;
            r_ov    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            if (en4) r_v4 <= i_valid;
            if (en5) r_ov <= r_v4;
            if (wr_en) r_fwd_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_req4  <= i_req;
            r_addr4 <= i_addr;
        end
        if (wr_en) begin
            r_fwd_addr <= r_addr4;
            r_fwd_data <= nv;
        end
        if (en5) begin
            r_dest     <= r_req4.dest_index;
            r_value    <= r_req4.ok ? nv : '0;
            r_in_slice <= r_req4.ok && is_pix;
            r_status   <= r_req4.status;
        end
    end

    assign o_valid      = r_ov;
    assign o_dest_index = r_dest;
    assign o_value      = r_value;
    assign o_in_slice   = r_in_slice;
    assign o_status     = r_status;

endmodule
